[rtl/core/bxds_pkg.sv]
`default_nettype none

package bxds_pkg;

  localparam int unsigned NumChan          = 3;
  localparam int unsigned PixW             = 8;
  localparam int unsigned CfgDataW         = 13;
  localparam int unsigned CfgIdxW          = 2;
  localparam int unsigned ScaleW           = 3;
  localparam int unsigned RowW             = 12;
  localparam int unsigned HgtW             = 13;
  localparam int unsigned OutPosW          = 12;
  localparam int unsigned HeightMax        = 4096;
  localparam int unsigned MaxWidthDef      = 4096;
  localparam int unsigned MaxScaleLog2Def  = 4;
  localparam int unsigned FifoDepth        = 3;

  localparam logic [CfgDataW-1:0] WidthRst  = CfgDataW'(1);
  localparam logic [CfgDataW-1:0] HeightRst = CfgDataW'(1);
  localparam logic [ScaleW-1:0]   ScaleRst  = ScaleW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMG_WIDTH  = 2'd0,
    CFG_IMG_HEIGHT = 2'd1,
    CFG_SCALE_LOG2 = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [NumChan-1:0][PixW-1:0] avg;
    logic [OutPosW-1:0]           out_col;
    logic [OutPosW-1:0]           out_row;
    logic                         row_end;
    logic                         frame_end;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/bxds_ram.sv]
`default_nettype none

module bxds_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/bxds_accum.sv]
`default_nettype none

module bxds_accum
  import bxds_pkg::*;
#(
  parameter int unsigned MaxWidth     = MaxWidthDef,
  parameter int unsigned MaxScaleLog2 = MaxScaleLog2Def,
  localparam int unsigned AW = $clog2(MaxWidth),
  localparam int unsigned WW = AW + 1,
  localparam int unsigned SW = PixW + 2 * MaxScaleLog2,
  localparam int unsigned KW = $clog2(MaxScaleLog2 + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic [PixW-1:0]     chan0_i,
  input  logic [PixW-1:0]     chan1_i,
  input  logic [PixW-1:0]     chan2_i,
  input  logic                room_i,
  output logic                in_ready_o,
  output logic                push_o,
  output res_t                res_o
);

  // configuration
  logic [CfgDataW-1:0] width_q, height_q;
  logic [ScaleW-1:0]   scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      scale_q  <= ScaleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_IMG_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_IMG_HEIGHT: height_q <= cfg_wdata_i;
        CFG_SCALE_LOG2: scale_q  <= cfg_wdata_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [CfgDataW-1:0] w_raw, h_raw;
  logic [WW-1:0]       w_eff, w_out, col_lim;
  logic [HgtW-1:0]     h_eff, h_out, row_lim;
  logic [KW-1:0]       k_eff;
  logic [AW-1:0]       cmask;
  logic [RowW-1:0]     rmask;

  always_comb begin
    w_raw = (width_q == '0) ? CfgDataW'(1) : width_q;
    h_raw = (height_q == '0) ? CfgDataW'(1) : height_q;
    if (32'(w_raw) > 32'(MaxWidth)) begin
      w_eff = WW'(MaxWidth);
    end else begin
      w_eff = WW'(w_raw);
    end
    if (32'(h_raw) > 32'(HeightMax)) begin
      h_eff = HgtW'(HeightMax);
    end else begin
      h_eff = HgtW'(h_raw);
    end
    if (32'(scale_q) > 32'(MaxScaleLog2)) begin
      k_eff = KW'(MaxScaleLog2);
    end else begin
      k_eff = KW'(scale_q);
    end
    w_out   = w_eff >> k_eff;
    h_out   = h_eff >> k_eff;
    col_lim = w_eff & ({WW{1'b1}} << k_eff);
    row_lim = h_eff & ({HgtW{1'b1}} << k_eff);
    cmask   = ~({AW{1'b1}} << k_eff);
    rmask   = ~({RowW{1'b1}} << k_eff);
  end

  // clearing pass over the line memory after reset
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (32'(clr_addr_q) == MaxWidth - 1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // stage 0: position, partial row sum, memory read issue
  logic [AW-1:0]                col_q, col_d;
  logic [RowW-1:0]              row_q, row_d;
  logic [NumChan-1:0][SW-1:0]   part_q, part_d, part_add;
  logic [NumChan-1:0][PixW-1:0] pix;
  logic                         fire, in_blk, col_end, row_last, rd_issue;
  logic                         rend, fend;
  logic [AW-1:0]                bc;
  logic [RowW-1:0]              orow;
  logic [WW-1:0]                col_nxt;
  logic [HgtW-1:0]              row_nxt;

  assign pix        = {chan2_i, chan1_i, chan0_i};
  assign in_ready_o = !clr_busy_q && room_i;
  assign fire       = in_valid_i && in_ready_o;

  assign in_blk   = ({1'b0, col_q} < col_lim) && ({1'b0, row_q} < row_lim);
  assign col_end  = (col_q & cmask) == cmask;
  assign row_last = (row_q & rmask) == rmask;
  assign bc       = col_q >> k_eff;
  assign orow     = row_q >> k_eff;
  assign rend     = ({1'b0, bc} == w_out - WW'(1));
  assign fend     = rend && ({1'b0, orow} == h_out - HgtW'(1));
  assign rd_issue = fire && in_blk && col_end;
  assign col_nxt  = {1'b0, col_q} + WW'(1);
  assign row_nxt  = {1'b0, row_q} + HgtW'(1);

  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      part_add[ch] = part_q[ch] + SW'(pix[ch]);
    end
    part_d = part_q;
    col_d  = col_q;
    row_d  = row_q;
    if (fire) begin
      if (in_blk) begin
        part_d = col_end ? '0 : part_add;
      end
      if (col_nxt >= w_eff) begin
        col_d  = '0;
        part_d = '0;
        row_d  = (row_nxt >= h_eff) ? '0 : row_nxt[RowW-1:0];
      end else begin
        col_d = col_nxt[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      part_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      part_q <= part_d;
    end
  end

  // stage 1: read data back, add, write back or emit
  logic                       s1_valid_q, s1_emit_q, s1_rend_q, s1_fend_q;
  logic [AW-1:0]              s1_addr_q;
  logic [NumChan-1:0][SW-1:0] s1_part_q;
  logic [KW-1:0]              s1_k_q;
  logic [RowW-1:0]            s1_row_q;
  logic                       fwd_q;
  logic [NumChan*SW-1:0]      fwd_data_q;
  logic [NumChan*SW-1:0]      ram_rdata, base, s1_wdata;
  logic [NumChan-1:0][SW-1:0] total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= rd_issue;
      // entry written this cycle is the one being read: RAM returns stale data
      fwd_q      <= rd_issue && s1_valid_q && (s1_addr_q == bc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      s1_emit_q  <= row_last;
      s1_addr_q  <= bc;
      s1_part_q  <= part_add;
      s1_k_q     <= k_eff;
      s1_row_q   <= orow;
      s1_rend_q  <= rend;
      s1_fend_q  <= fend;
      fwd_data_q <= s1_wdata;
    end
  end

  assign base = fwd_q ? fwd_data_q : ram_rdata;

  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      total[ch] = base[ch*SW +: SW] + s1_part_q[ch];
    end
    s1_wdata = s1_emit_q ? '0 : total;
    for (int ch = 0; ch < NumChan; ch++) begin
      res_o.avg[ch] = PixW'(total[ch] >> {s1_k_q, 1'b0});
    end
    res_o.out_col   = OutPosW'(s1_addr_q);
    res_o.out_row   = OutPosW'(s1_row_q);
    res_o.row_end   = s1_rend_q;
    res_o.frame_end = s1_fend_q;
  end

  assign push_o = s1_valid_q && s1_emit_q;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [NumChan*SW-1:0] ram_wdata;

  assign ram_we    = clr_busy_q || s1_valid_q;
  assign ram_waddr = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_busy_q ? '0 : s1_wdata;

  bxds_ram #(
    .Width(NumChan * SW),
    .Depth(MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_issue),
    .raddr_i (bc),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  a_s1_from_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_issue |=> s1_valid_q)
    else $error("stage 1 lost a read");
  a_fwd_needs_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q && $past(s1_valid_q))
    else $error("forward without a preceding write");
  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !clr_busy_q)
    else $error("line memory write collides with clearing pass");
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < MaxWidth)
    else $error("column counter out of range");
`endif

endmodule

`default_nettype wire

[rtl/core/bxds_out_fifo.sv]
`default_nettype none

module bxds_out_fifo
  import bxds_pkg::*;
#(
  localparam int unsigned PW = $clog2(FifoDepth),
  localparam int unsigned CW = $clog2(FifoDepth + 1)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic room_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  res_t          mem_q [FifoDepth];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign res_o       = mem_q[rd_q];
  // one slot is held back for a result already in flight
  assign room_o      = ({1'b0, cnt_q} + (CW + 1)'(push_i)) < (CW + 1)'(FifoDepth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (32'(wr_q) == FifoDepth - 1) ? '0 : wr_q + PW'(1);
      end
      if (pop) begin
        rd_q <= (32'(rd_q) == FifoDepth - 1) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= res_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (32'(cnt_q) < FifoDepth) || pop)
    else $error("result queue overflow");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= FifoDepth)
    else $error("result queue count out of range");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("result queue count did not advance");
`endif

endmodule

`default_nettype wire

[rtl/core/box_average_downscale.sv]
// Channel  Dir  Handshake                  Payload
// in       in   in_valid_i / in_ready_o    chan0_i, chan1_i, chan2_i
// out      out  out_valid_o / out_ready_i  avg_chan0_o..avg_chan2_o, out_col_o,
//                                          out_row_o, row_end_o, frame_end_o
// cfg      in   cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// One pixel item per cycle while in_ready_o is high; a block result for the item
// holding the block's bottom-right pixel passes a line memory read, then add/write.
// After reset a clearing pass zeroes the line memory with in_ready_o low; config
// writes are taken during it.
// A three-entry result queue absorbs output stalls; in_ready_o otherwise drops only
// when it could fill up.
`default_nettype none

module box_average_downscale
  import bxds_pkg::*;
#(
  parameter int unsigned MaxWidth     = MaxWidthDef,
  parameter int unsigned MaxScaleLog2 = MaxScaleLog2Def
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PixW-1:0]     chan0_i,
  input  logic [PixW-1:0]     chan1_i,
  input  logic [PixW-1:0]     chan2_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PixW-1:0]     avg_chan0_o,
  output logic [PixW-1:0]     avg_chan1_o,
  output logic [PixW-1:0]     avg_chan2_o,
  output logic [OutPosW-1:0]  out_col_o,
  output logic [OutPosW-1:0]  out_row_o,
  output logic                row_end_o,
  output logic                frame_end_o
);

  logic room, push;
  res_t res_acc, res_out;

  bxds_accum #(
    .MaxWidth    (MaxWidth),
    .MaxScaleLog2(MaxScaleLog2)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .chan0_i     (chan0_i),
    .chan1_i     (chan1_i),
    .chan2_i     (chan2_i),
    .room_i      (room),
    .in_ready_o  (in_ready_o),
    .push_o      (push),
    .res_o       (res_acc)
  );

  bxds_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res_acc),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign avg_chan0_o = res_out.avg[0];
  assign avg_chan1_o = res_out.avg[1];
  assign avg_chan2_o = res_out.avg[2];
  assign out_col_o   = res_out.out_col;
  assign out_row_o   = res_out.out_row;
  assign row_end_o   = res_out.row_end;
  assign frame_end_o = res_out.frame_end;

endmodule

`default_nettype wire

[tb/box_scaler_checker.sv]
`timescale 1ns / 100ps

module box_scaler_checker
  import bxds_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [PixW-1:0]     chan0_i,
  input  logic [PixW-1:0]     chan1_i,
  input  logic [PixW-1:0]     chan2_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [PixW-1:0]     avg_chan0_i,
  input  logic [PixW-1:0]     avg_chan1_i,
  input  logic [PixW-1:0]     avg_chan2_i,
  input  logic [OutPosW-1:0]  out_col_i,
  input  logic [OutPosW-1:0]  out_row_i,
  input  logic                row_end_i,
  input  logic                frame_end_i,
  output int                  pending_o,
  output int                  errors_o
);

  localparam int ReportMax = 10;

  logic [CfgDataW-1:0] width_q;
  logic [CfgDataW-1:0] height_q;
  logic [ScaleW-1:0]   scale_q;
  int unsigned         col_pos;
  int unsigned         row_pos;
  // running sum of the current block row segment, and finished rows per block column
  int unsigned         seg_sum [NumChan];
  int unsigned         col_sum [MaxWidthDef][NumChan];
  res_t                block_avg_q [$];

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned                  w, h, k, mask, bc;
    logic [NumChan-1:0][PixW-1:0] px;
    res_t                         got, want;
    if (!rst_ni) begin
      width_q   = WidthRst;
      height_q  = HeightRst;
      scale_q   = ScaleRst;
      col_pos   = 0;
      row_pos   = 0;
      pending_o = 0;
      errors_o  = 0;
      foreach (seg_sum[c]) seg_sum[c] = 0;
      foreach (col_sum[i, c]) col_sum[i][c] = 0;
      block_avg_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMG_WIDTH:  width_q  = cfg_wdata_i;
          CFG_IMG_HEIGHT: height_q = cfg_wdata_i;
          CFG_SCALE_LOG2: scale_q  = cfg_wdata_i[ScaleW-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        w = (width_q == 0) ? 1 : (width_q > MaxWidthDef) ? MaxWidthDef : width_q;
        h = (height_q == 0) ? 1 : (height_q > HeightMax) ? HeightMax : height_q;
        k = (scale_q > MaxScaleLog2Def) ? MaxScaleLog2Def : scale_q;
        mask = (1 << k) - 1;
        px = {chan2_i, chan1_i, chan0_i};
        // pixels right of / below the last whole block are dropped
        if (col_pos < ((w >> k) << k) && row_pos < ((h >> k) << k)) begin
          bc = col_pos >> k;
          for (int c = 0; c < NumChan; c++) seg_sum[c] += px[c];
          if ((col_pos & mask) == mask) begin
            if ((row_pos & mask) == mask) begin
              for (int c = 0; c < NumChan; c++) begin
                want.avg[c] = PixW'((col_sum[bc][c] + seg_sum[c]) >> (2 * k));
                col_sum[bc][c] = 0;
              end
              want.out_col   = OutPosW'(bc);
              want.out_row   = OutPosW'(row_pos >> k);
              want.row_end   = (bc == (w >> k) - 1);
              want.frame_end = want.row_end && ((row_pos >> k) == (h >> k) - 1);
              block_avg_q.push_back(want);
            end else begin
              for (int c = 0; c < NumChan; c++) col_sum[bc][c] += seg_sum[c];
            end
            foreach (seg_sum[c]) seg_sum[c] = 0;
          end
        end
        col_pos++;
        if (col_pos >= w) begin
          col_pos = 0;
          foreach (seg_sum[c]) seg_sum[c] = 0;
          row_pos++;
          if (row_pos >= h) row_pos = 0;
        end
      end

      if (out_valid_i && out_ready_i) begin
        got = {{avg_chan2_i, avg_chan1_i, avg_chan0_i}, out_col_i, out_row_i,
               row_end_i, frame_end_i};
        if (block_avg_q.size() == 0) begin
          errors_o++;
          if (errors_o <= ReportMax)
            $display("%0t: unexpected item: avg %0d,%0d,%0d col %0d row %0d ends %b%b",
                     $time, got.avg[0], got.avg[1], got.avg[2], got.out_col, got.out_row,
                     got.row_end, got.frame_end);
        end else begin
          want = block_avg_q.pop_front();
          if (got !== want) begin
            errors_o++;
            if (errors_o <= ReportMax)
              $display("%0t: mismatch: expected avg %0d,%0d,%0d col %0d row %0d ends %b%b",
                       $time, want.avg[0], want.avg[1], want.avg[2], want.out_col,
                       want.out_row, want.row_end, want.frame_end,
                       " / got avg %0d,%0d,%0d col %0d row %0d ends %b%b",
                       got.avg[0], got.avg[1], got.avg[2], got.out_col, got.out_row,
                       got.row_end, got.frame_end);
          end
        end
      end
      pending_o = block_avg_q.size();
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import bxds_pkg::*;

  localparam int                 NumRandItems = 750;
  localparam int                 MaxGap       = 18;
  localparam int                 HoldCycles   = 160;
  localparam int                 DrainCycles  = 8;
  localparam int                 RunLimitNs   = 1_000_000;
  // index with no register behind it; writes must be ignored
  localparam logic [CfgIdxW-1:0] CfgIdxSpare  = CfgIdxW'(3);

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                px_valid  = 1'b0;
  logic                px_ready;
  logic [PixW-1:0]     px_c0     = '0;
  logic [PixW-1:0]     px_c1     = '0;
  logic [PixW-1:0]     px_c2     = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  logic [PixW-1:0]     avg_c0, avg_c1, avg_c2;
  logic [OutPosW-1:0]  res_col, res_row;
  logic                res_row_end, res_frame_end;
  int                  pending, errors;
  int                  n_sent      = 0;
  bit                  tx_burst    = 1'b0;
  bit                  rx_burst    = 1'b0;
  bit                  rx_hold_req = 1'b0;

  always #1 clk = ~clk;

  box_average_downscale dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (px_valid),
    .in_ready_o (px_ready),
    .chan0_i    (px_c0),
    .chan1_i    (px_c1),
    .chan2_i    (px_c2),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .avg_chan0_o(avg_c0),
    .avg_chan1_o(avg_c1),
    .avg_chan2_o(avg_c2),
    .out_col_o  (res_col),
    .out_row_o  (res_row),
    .row_end_o  (res_row_end),
    .frame_end_o(res_frame_end)
  );

  box_scaler_checker u_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (px_valid),
    .in_ready_i (px_ready),
    .chan0_i    (px_c0),
    .chan1_i    (px_c1),
    .chan2_i    (px_c2),
    .out_valid_i(res_valid),
    .out_ready_i(res_ready),
    .avg_chan0_i(avg_c0),
    .avg_chan1_i(avg_c1),
    .avg_chan2_i(avg_c2),
    .out_col_i  (res_col),
    .out_row_i  (res_row),
    .row_end_i  (res_row_end),
    .frame_end_i(res_frame_end),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  function automatic logic [PixW-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_px(input logic [PixW-1:0] c0, c1, c2);
    int gap;
    if ($urandom_range(0, 23) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      px_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    px_valid <= 1'b1;
    px_c0    <= c0;
    px_c1    <= c1;
    px_c2    <= c2;
    @(posedge clk);
    while (!px_ready) @(posedge clk);
    n_sent++;
  endtask

  // drop valid, wait for every block result, then let the pipeline drain
  task automatic settle();
    px_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic program_regs(input logic [CfgDataW-1:0] w, h, s);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_IMG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_idx   <= CFG_IMG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_idx   <= CFG_SCALE_LOG2;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_idx   <= CfgIdxSpare;
    cfg_wdata <= CfgDataW'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned         k, blk, w, h, pix, n;
    int                  base;
    logic [CfgDataW-1:0] s_reg;
    bit                  broken;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: 1x1 image, 2x2 blocks -> nothing comes out
    send_px('1, '1, '1);
    settle();

    // zero size reads as 1; scale 0 passes every pixel through
    program_regs('0, '0, '0);
    send_px('0, '0, '0);
    send_px('1, '1, '1);
    settle();

    // one 2x2 block, floor of the average
    program_regs(2, 2, 1);
    send_px(8'd255, 8'd0, 8'd128);
    send_px(8'd255, 8'd0, 8'd127);
    send_px(8'd255, 8'd0, 8'd128);
    send_px(8'd254, 8'd0, 8'd128);
    settle();

    // height shrinks mid-frame
    program_regs(4, 8, 1);
    repeat (4) send_px(rand_chan(), rand_chan(), rand_chan());
    settle();
    program_regs(4, 2, 1);
    repeat (4) send_px(rand_chan(), rand_chan(), rand_chan());
    settle();

    // width drops below the current column mid-frame
    program_regs(6, 2, 1);
    repeat (4) send_px(rand_chan(), rand_chan(), rand_chan());
    settle();
    program_regs(2, 2, 1);
    repeat (3) send_px(rand_chan(), rand_chan(), rand_chan());
    settle();

    // oversize width, height and scale all saturate
    program_regs('1, '1, '1);
    repeat (2) send_px(rand_chan(), rand_chan(), rand_chan());
    settle();
    program_regs(1, 1, 1);
    send_px(rand_chan(), rand_chan(), rand_chan());
    settle();

    base = n_sent;
    for (int ph = 0; n_sent - base < NumRandItems; ph++) begin
      if (ph == 0) begin
        k = 0;
      end else begin
        case ($urandom_range(0, 7))
          0, 1:    k = 0;
          2, 3:    k = 1;
          4, 5:    k = 2;
          6:       k = 3;
          default: k = 4;
        endcase
      end
      blk = 1 << k;
      if (k == 0) begin
        w = (ph == 0) ? $urandom_range(6, 12) : $urandom_range(1, 12);
        h = (ph == 0) ? $urandom_range(4, 6) : $urandom_range(1, 8);
      end else begin
        w = blk * ((k >= 3) ? 1 : $urandom_range(1, 3)) +
            $urandom_range(0, (k == 4) ? 3 : blk - 1);
        h = blk * ((k >= 2) ? 1 : $urandom_range(1, 3)) +
            $urandom_range(0, (k == 4) ? 3 : blk - 1);
        // image smaller than one block now and then
        if ($urandom_range(0, 9) == 0) w = $urandom_range(0, blk - 1);
        else if ($urandom_range(0, 9) == 0) h = $urandom_range(0, blk - 1);
      end
      pix = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      n = pix * ((pix < 120) ? $urandom_range(1, 2) : 1);

      s_reg = CfgDataW'(k);
      if (k == 4) s_reg[ScaleW-1:0] = ScaleW'($urandom_range(4, 7));
      if ($urandom_range(0, 3) == 0) s_reg = s_reg | (CfgDataW'($urandom) << ScaleW);

      broken = (ph != 0) && ($urandom_range(0, 5) == 0);
      if (broken) n = $urandom_range(1, n);
      if (ph == 0) begin
        rx_hold_req = 1'b1;
        tx_burst    = 1'b1;
      end

      program_regs(CfgDataW'(w), CfgDataW'(h), s_reg);
      for (int i = 0; i < n; i++) send_px(rand_chan(), rand_chan(), rand_chan());
      settle();
      if (broken) begin
        // a 1x1 image brings the position back to the origin in one item
        program_regs(1, 1, s_reg);
        send_px(rand_chan(), rand_chan(), rand_chan());
        settle();
      end
    end

    if (errors == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        res_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      if ($urandom_range(0, 23) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  initial begin : watchdog
    #RunLimitNs;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
